// File: design/wsd_pkg.sv
package wsd_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } ph_t;

  // result kinds
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // seven-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header byte counts
  localparam logic [3:0] HDR_BASE    = 4'd2;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// File: design/websocket_frame_deframer.sv
// WebSocket receive-side deframer. Stream bytes come in one item per cycle on
// the in_ channel; each frame yields one header descriptor item (opcode, fin,
// mask flag and key, 32-bit payload length, header size) once its last header
// byte arrives, then one item per payload byte with out_last on the final
// one. A zero-length frame flags its descriptor as last. Payload bytes pass
// through as received, not unmasked, and an eight-byte length keeps its low
// 32 bits. in_restart drops the frame in progress and returns to the first
// header byte. The block takes one byte per cycle unless the consumer stalls:
// each byte is parsed combinationally straight into the output register, and
// a new byte is taken whenever that register is empty or being drained.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [3:0]  out_opcode,
  output logic        out_fin,
  output logic        out_masked,
  output logic [31:0] out_key_word,
  output logic [31:0] out_frame_length,
  output logic [3:0]  out_hdr_len,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);
  import wsd_pkg::*;

  // parser state
  ph_t         phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [3:0]  ext_len_r, ext_len_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic        masked_r, masked_nxt;
  logic [31:0] length_acc_r, length_acc_nxt;
  logic [31:0] key_acc_r, key_acc_nxt;
  logic [31:0] remaining_r, remaining_nxt;

  // per-byte control
  logic        in_fire;
  logic        emit_desc;
  logic        emit_data;
  logic        data_done;
  logic [3:0]  cnt_inc;
  logic [6:0]  len7;

  // result being formed
  logic        res_valid;
  logic        res_kind;
  logic [31:0] res_key;
  logic [3:0]  res_hdr_size;
  logic [7:0]  res_payload;
  logic        res_last;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [3:0]  out_opcode_r;
  logic        out_fin_r;
  logic        out_masked_r;
  logic [31:0] out_key_word_r;
  logic [31:0] out_frame_length_r;
  logic [3:0]  out_hdr_len_r;
  logic [7:0]  out_payload_byte_r;
  logic        out_last_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cnt_inc  = byte_count_r + 4'd1;
  assign len7     = in_data_byte[6:0];

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    ext_len_nxt    = ext_len_r;
    opcode_nxt     = opcode_r;
    fin_nxt        = fin_r;
    masked_nxt     = masked_r;
    length_acc_nxt = length_acc_r;
    key_acc_nxt    = key_acc_r;
    remaining_nxt  = remaining_r;
    emit_desc      = 1'b0;
    emit_data      = 1'b0;
    data_done      = 1'b0;
    if (in_restart) begin
      phase_nxt      = PH_HDR0;
      byte_count_nxt = '0;
    end else begin
      case (phase_r)
        PH_HDR1: begin
          masked_nxt     = in_data_byte[7];
          key_acc_nxt    = '0;
          byte_count_nxt = '0;
          if (len7 == LEN_EXT16) begin
            ext_len_nxt    = EXT16_BYTES;
            length_acc_nxt = '0;
            phase_nxt      = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            ext_len_nxt    = EXT64_BYTES;
            length_acc_nxt = '0;
            phase_nxt      = PH_EXT;
          end else begin
            ext_len_nxt    = '0;
            length_acc_nxt = {25'd0, len7};
            if (in_data_byte[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              emit_desc = 1'b1;
            end
          end
        end
        PH_EXT: begin
          length_acc_nxt = {length_acc_r[23:0], in_data_byte};
          if (cnt_inc < ext_len_r) begin
            byte_count_nxt = cnt_inc;
          end else begin
            byte_count_nxt = '0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else begin
              emit_desc = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_acc_nxt = {key_acc_r[23:0], in_data_byte};
          if (cnt_inc < KEY_BYTES) begin
            byte_count_nxt = cnt_inc;
          end else begin
            byte_count_nxt = '0;
            emit_desc      = 1'b1;
          end
        end
        PH_DATA: begin
          emit_data     = 1'b1;
          remaining_nxt = remaining_r - 32'd1;
          if (remaining_nxt == 32'd0) begin
            data_done = 1'b1;
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          fin_nxt        = in_data_byte[7];
          opcode_nxt     = in_data_byte[3:0];
          byte_count_nxt = '0;
          phase_nxt      = PH_HDR1;
        end
      endcase
      // header complete: empty frame ends here, else go to payload
      if (emit_desc) begin
        if (length_acc_nxt == 32'd0) begin
          phase_nxt = PH_HDR0;
        end else begin
          remaining_nxt = length_acc_nxt;
          phase_nxt     = PH_DATA;
        end
      end
    end
  end

  // result fields
  always_comb begin
    res_valid    = emit_desc || emit_data;
    res_kind     = emit_data ? KIND_DATA : KIND_DESC;
    res_key      = masked_nxt ? key_acc_nxt : 32'd0;
    res_hdr_size = HDR_BASE + ext_len_nxt + (masked_nxt ? KEY_BYTES : 4'd0);
    res_payload  = emit_data ? in_data_byte : 8'd0;
    res_last     = emit_data ? data_done : (length_acc_nxt == 32'd0);
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      byte_count_r <= '0;
      ext_len_r    <= '0;
      opcode_r     <= '0;
      fin_r        <= 1'b0;
      masked_r     <= 1'b0;
      length_acc_r <= '0;
      key_acc_r    <= '0;
      remaining_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        byte_count_r <= byte_count_nxt;
        ext_len_r    <= ext_len_nxt;
        opcode_r     <= opcode_nxt;
        fin_r        <= fin_nxt;
        masked_r     <= masked_nxt;
        length_acc_r <= length_acc_nxt;
        key_acc_r    <= key_acc_nxt;
        remaining_r  <= remaining_nxt;
      end
      if (in_fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r         <= res_kind;
      out_opcode_r       <= opcode_nxt;
      out_fin_r          <= fin_nxt;
      out_masked_r       <= masked_nxt;
      out_key_word_r     <= res_key;
      out_frame_length_r <= length_acc_nxt;
      out_hdr_len_r      <= res_hdr_size;
      out_payload_byte_r <= res_payload;
      out_last_r         <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_opcode       = out_opcode_r;
  assign out_fin          = out_fin_r;
  assign out_masked       = out_masked_r;
  assign out_key_word     = out_key_word_r;
  assign out_frame_length = out_frame_length_r;
  assign out_hdr_len      = out_hdr_len_r;
  assign out_payload_byte = out_payload_byte_r;
  assign out_last         = out_last_r;

endmodule
